/* hw/rtl/cfgnt_pkg.sv */
// Shared types and constants of the frame group and node table.
package cfgnt_pkg;

    localparam int ID_W      = 16;
    localparam int UUID_W    = 16;
    localparam int SIZE_W    = 4;
    localparam int PAYLOAD_W = 64;
    localparam int TIME_W    = 32;
    localparam int COUNT_W   = 32;
    localparam int TYPE_W    = 8;
    localparam int STAT_W    = 2;
    localparam int GIDX_W    = 5;
    localparam int NIDX_W    = 4;

    localparam int IN_BITS   = ID_W + UUID_W + SIZE_W + PAYLOAD_W + TIME_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = STAT_W + GIDX_W + COUNT_W + STAT_W + NIDX_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEARTBEAT_ID = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLY_ID     = 8'd1;

    // frame_status codes
    localparam logic [STAT_W-1:0] FS_COUNTED = 2'd0;
    localparam logic [STAT_W-1:0] FS_OPENED  = 2'd1;
    localparam logic [STAT_W-1:0] FS_DROPPED = 2'd2;
    localparam logic [STAT_W-1:0] FS_EMPTY   = 2'd3;

    // node_status codes
    localparam logic [STAT_W-1:0] NS_NONE    = 2'd0;
    localparam logic [STAT_W-1:0] NS_KNOWN   = 2'd1;
    localparam logic [STAT_W-1:0] NS_LEARNED = 2'd2;
    localparam logic [STAT_W-1:0] NS_FULL    = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]      key_id;
        logic [UUID_W-1:0]    key_uuid;
        logic [COUNT_W-1:0]   frames;
        logic [PAYLOAD_W-1:0] last_payload;
        logic [SIZE_W-1:0]    last_size;
        logic [TIME_W-1:0]    last_time;
    } t_grp_entry;

    typedef struct packed {
        logic [UUID_W-1:0] uuid;
        logic [TYPE_W-1:0] node_type;
    } t_node_entry;

endpackage

/* hw/rtl/can_frame_group_and_node_table.sv */
// Frame group table and node table: top level.
//
// Input stream (s_axis): one bus frame per transaction. Output stream (m_axis): one
// result per frame, in order. Config channel: register 0 heartbeat id, register 1
// reply id; write only while no frame is in flight. o_cfg_ready is always high.
//
// Group and node entries live in two single-port-read RAMs and fill from entry 0
// upward without ever being freed, so a fill count marks the valid entries.
// A frame scans the group RAM one entry per cycle through the registered read port,
// and a heartbeat or reply frame that finds or opens a group then scans the node RAM
// the same way. A scan stops at a hit or at the fill count. An empty frame skips both
// scans; every frame is accepted, scanned as above, then loaded into the output register.
// The group RAM scan sets the rate.
// o_s_axis_tready is high only while idle; a result sitting in the output register
// does not block the next frame, but a finished frame waits for that register
// to empty when the receiver stalls.
// Reset empties both tables, clears the ids to 0 and drops any pending result.
module can_frame_group_and_node_table #(
    parameter int GROUP_ENTRIES = 32,
    parameter int NODE_ENTRIES  = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // config write channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [cfgnt_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [cfgnt_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // frame input
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // can_id[15:0], sender_uuid[31:16], byte_count[35:32], payload[99:36],
    // time_ms[131:100], zero[135:132]
    input  logic [cfgnt_pkg::IN_DATA_W-1:0]        i_s_axis_tdata,
    // result output
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // frame_status[1:0], group_index[6:2], group_count[38:7], node_status[40:39],
    // node_index[44:41], zero[47:45]
    output logic [cfgnt_pkg::OUT_DATA_W-1:0]       o_m_axis_tdata
);

    localparam int GAW = (GROUP_ENTRIES > 1) ? $clog2(GROUP_ENTRIES) : 1;
    localparam int GCW = $clog2(GROUP_ENTRIES + 1);
    localparam int NAW = (NODE_ENTRIES > 1) ? $clog2(NODE_ENTRIES) : 1;
    localparam int NCW = $clog2(NODE_ENTRIES + 1);
    localparam int GIW = cfgnt_pkg::GIDX_W;
    localparam int NIW = cfgnt_pkg::NIDX_W;
    localparam int SW  = cfgnt_pkg::STAT_W;
    localparam int CW  = cfgnt_pkg::COUNT_W;
    localparam int PADW = cfgnt_pkg::OUT_DATA_W - cfgnt_pkg::OUT_BITS;

    typedef enum logic [1:0] {ST_IDLE, ST_GSCAN, ST_NSCAN, ST_DONE} t_state;

    t_state r_state, n_state;

    logic [cfgnt_pkg::ID_W-1:0] r_heartbeat_id, n_heartbeat_id;
    logic [cfgnt_pkg::ID_W-1:0] r_reply_id, n_reply_id;

    // frame under work
    logic [cfgnt_pkg::ID_W-1:0]      r_id;
    logic [cfgnt_pkg::UUID_W-1:0]    r_uuid;
    logic [cfgnt_pkg::SIZE_W-1:0]    r_size;
    logic [cfgnt_pkg::PAYLOAD_W-1:0] r_payload;
    logic [cfgnt_pkg::TIME_W-1:0]    r_time;

    logic [GCW-1:0] r_gfill, n_gfill, r_gaddr, n_gaddr;
    logic [NCW-1:0] r_nfill, n_nfill, r_naddr, n_naddr;
    logic           r_gpend, n_gpend, r_npend, n_npend;

    // result being built
    logic [SW-1:0]  r_fstat, n_fstat, r_nstat, n_nstat;
    logic [GAW-1:0] r_slot, n_slot;
    logic [CW-1:0]  r_count, n_count;
    logic [NAW-1:0] r_nidx, n_nidx;

    // output register
    logic           r_out_valid, n_out_valid;
    logic [SW-1:0]  r_o_fstat, n_o_fstat, r_o_nstat, n_o_nstat;
    logic [GIW-1:0] r_o_gidx, n_o_gidx;
    logic [CW-1:0]  r_o_count, n_o_count;
    logic [NIW-1:0] r_o_nidx, n_o_nidx;

    logic s_accept, frame_empty, presence;

    logic                  g_we, g_re, g_hit, g_more, g_open;
    logic [GAW-1:0]        g_waddr;
    cfgnt_pkg::t_grp_entry g_wdata, g_rdata;
    logic [CW-1:0]         g_cnt_new;

    logic                   nd_we, nd_re, nd_hit, nd_more;
    logic [NAW-1:0]         nd_waddr;
    cfgnt_pkg::t_node_entry nd_wdata, nd_rdata;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign frame_empty     = (i_s_axis_tdata[15:0] == '0) && (i_s_axis_tdata[31:16] == '0)
                             && (i_s_axis_tdata[35:32] == '0);
    assign presence        = (r_id == r_heartbeat_id) || (r_id == r_reply_id);

    // group RAM: read data belongs to entry r_gaddr - 1 when r_gpend is set
    assign g_hit     = r_gpend && (g_rdata.key_id == r_id) && (g_rdata.key_uuid == r_uuid);
    assign g_more    = (r_gaddr != r_gfill);
    assign g_open    = (r_state == ST_GSCAN) && !g_hit && !g_more
                       && (r_gfill != GCW'(GROUP_ENTRIES));
    assign g_cnt_new = g_hit ? (g_rdata.frames + CW'(1)) : CW'(1);
    assign g_waddr   = g_hit ? GAW'(r_gaddr - GCW'(1)) : r_gfill[GAW-1:0];
    assign g_we      = (r_state == ST_GSCAN) && (g_hit || g_open);
    assign g_re      = (r_state == ST_GSCAN) && !g_hit && g_more;

    always_comb begin
        g_wdata.key_id       = r_id;
        g_wdata.key_uuid     = r_uuid;
        g_wdata.frames       = g_cnt_new;
        g_wdata.last_payload = r_payload;
        g_wdata.last_size    = r_size;
        g_wdata.last_time    = r_time;
    end

    assign nd_hit   = r_npend && (nd_rdata.uuid == r_uuid);
    assign nd_more  = (r_naddr != r_nfill);
    assign nd_waddr = r_nfill[NAW-1:0];
    assign nd_we    = (r_state == ST_NSCAN) && !nd_hit && !nd_more
                      && (r_nfill != NCW'(NODE_ENTRIES));
    assign nd_re    = (r_state == ST_NSCAN) && !nd_hit && nd_more;

    always_comb begin
        nd_wdata.uuid      = r_uuid;
        nd_wdata.node_type = (r_size != '0) ? r_payload[7:0] : '0;
    end

    cfgnt_ram #(
        .WIDTH ($bits(cfgnt_pkg::t_grp_entry)),
        .DEPTH (GROUP_ENTRIES)
    ) u_grp_ram (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (g_waddr),
        .i_wdata (g_wdata),
        .i_re    (g_re),
        .i_raddr (r_gaddr[GAW-1:0]),
        .o_rdata (g_rdata)
    );

    cfgnt_ram #(
        .WIDTH ($bits(cfgnt_pkg::t_node_entry)),
        .DEPTH (NODE_ENTRIES)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (nd_we),
        .i_waddr (nd_waddr),
        .i_wdata (nd_wdata),
        .i_re    (nd_re),
        .i_raddr (r_naddr[NAW-1:0]),
        .o_rdata (nd_rdata)
    );

    always_comb begin
        n_state        = r_state;
        n_heartbeat_id = r_heartbeat_id;
        n_reply_id     = r_reply_id;
        n_gfill        = r_gfill;
        n_gaddr        = r_gaddr;
        n_gpend        = r_gpend;
        n_nfill        = r_nfill;
        n_naddr        = r_naddr;
        n_npend        = r_npend;
        n_fstat        = r_fstat;
        n_nstat        = r_nstat;
        n_slot         = r_slot;
        n_count        = r_count;
        n_nidx         = r_nidx;
        n_out_valid    = r_out_valid && !i_m_axis_tready;
        n_o_fstat      = r_o_fstat;
        n_o_gidx       = r_o_gidx;
        n_o_count      = r_o_count;
        n_o_nstat      = r_o_nstat;
        n_o_nidx       = r_o_nidx;

        if (i_cfg_valid) begin
            if (i_cfg_index == cfgnt_pkg::CFG_HEARTBEAT_ID) begin
                n_heartbeat_id = i_cfg_data;
            end else if (i_cfg_index == cfgnt_pkg::CFG_REPLY_ID) begin
                n_reply_id = i_cfg_data;
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_fstat = cfgnt_pkg::FS_EMPTY;
                    n_nstat = cfgnt_pkg::NS_NONE;
                    n_slot  = '0;
                    n_count = '0;
                    n_nidx  = '0;
                    n_gaddr = '0;
                    n_gpend = 1'b0;
                    n_state = frame_empty ? ST_DONE : ST_GSCAN;
                end
            end
            ST_GSCAN: begin
                if (g_hit || g_open) begin
                    n_fstat = g_hit ? cfgnt_pkg::FS_COUNTED : cfgnt_pkg::FS_OPENED;
                    n_slot  = g_waddr;
                    n_count = g_cnt_new;
                    if (g_open) begin
                        n_gfill = r_gfill + GCW'(1);
                    end
                    n_naddr = '0;
                    n_npend = 1'b0;
                    n_state = presence ? ST_NSCAN : ST_DONE;
                end else if (g_more) begin
                    n_gaddr = r_gaddr + GCW'(1);
                    n_gpend = 1'b1;
                end else begin
                    n_fstat = cfgnt_pkg::FS_DROPPED;
                    n_state = ST_DONE;
                end
            end
            ST_NSCAN: begin
                if (nd_hit) begin
                    n_nstat = cfgnt_pkg::NS_KNOWN;
                    n_nidx  = NAW'(r_naddr - NCW'(1));
                    n_state = ST_DONE;
                end else if (nd_more) begin
                    n_naddr = r_naddr + NCW'(1);
                    n_npend = 1'b1;
                end else if (nd_we) begin
                    n_nstat = cfgnt_pkg::NS_LEARNED;
                    n_nidx  = nd_waddr;
                    n_nfill = r_nfill + NCW'(1);
                    n_state = ST_DONE;
                end else begin
                    n_nstat = cfgnt_pkg::NS_FULL;
                    n_nidx  = '0;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_o_fstat   = r_fstat;
                    n_o_gidx    = GIW'(r_slot);
                    n_o_count   = r_count;
                    n_o_nstat   = r_nstat;
                    n_o_nidx    = NIW'(r_nidx);
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_heartbeat_id <= '0;
            r_reply_id     <= '0;
            r_gfill        <= '0;
            r_gaddr        <= '0;
            r_gpend        <= 1'b0;
            r_nfill        <= '0;
            r_naddr        <= '0;
            r_npend        <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_heartbeat_id <= n_heartbeat_id;
            r_reply_id     <= n_reply_id;
            r_gfill        <= n_gfill;
            r_gaddr        <= n_gaddr;
            r_gpend        <= n_gpend;
            r_nfill        <= n_nfill;
            r_naddr        <= n_naddr;
            r_npend        <= n_npend;
            r_out_valid    <= n_out_valid;
        end
        r_fstat   <= n_fstat;
        r_nstat   <= n_nstat;
        r_slot    <= n_slot;
        r_count   <= n_count;
        r_nidx    <= n_nidx;
        r_o_fstat <= n_o_fstat;
        r_o_gidx  <= n_o_gidx;
        r_o_count <= n_o_count;
        r_o_nstat <= n_o_nstat;
        r_o_nidx  <= n_o_nidx;
        if (s_accept) begin
            r_id      <= i_s_axis_tdata[15:0];
            r_uuid    <= i_s_axis_tdata[31:16];
            r_size    <= i_s_axis_tdata[35:32];
            r_payload <= i_s_axis_tdata[99:36];
            r_time    <= i_s_axis_tdata[131:100];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{PADW{1'b0}}, r_o_nidx, r_o_nstat, r_o_count, r_o_gidx,
                              r_o_fstat};

`ifndef SYNTHESIS
    a_gfill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gfill <= GCW'(GROUP_ENTRIES))
        else $error("group fill count beyond table depth");

    a_nfill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nfill <= NCW'(NODE_ENTRIES))
        else $error("node fill count beyond table depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state != ST_IDLE))
        else $error("accepted frame did not start work");

    a_open_grows_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        g_open |=> (r_gfill == $past(r_gfill) + GCW'(1)))
        else $error("group opened without fill count advance");
`endif

endmodule

/* hw/rtl/cfgnt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module cfgnt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
